// File: hdl/cwc_pkg.sv
package cwc_pkg;

   localparam int MODE_BITS  = 3;
   localparam int FIELD_BITS = 32;
   localparam int CSR_IDX_BITS = 8;

   localparam logic [MODE_BITS-1:0] MODE_SENT      = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_ACKED     = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_LOST      = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_ACK_RX    = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_TIMEOUT   = 3'd4;
   localparam logic [MODE_BITS-1:0] MODE_DUP_ACK   = 3'd5;
   localparam logic [MODE_BITS-1:0] MODE_AVOID     = 3'd6;
   localparam logic [MODE_BITS-1:0] MODE_CLR_INFL  = 3'd7;

   localparam logic [CSR_IDX_BITS-1:0] CSR_INIT_WINDOW    = 8'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INIT_THRESHOLD = 8'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_WINDOW     = 8'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_WINDOW     = 8'd3;

   localparam logic [FIELD_BITS-1:0] RST_INIT_WINDOW    = 32'd10;
   localparam logic [FIELD_BITS-1:0] RST_INIT_THRESHOLD = 32'd64;
   localparam logic [FIELD_BITS-1:0] RST_MIN_WINDOW     = 32'd1;
   localparam logic [FIELD_BITS-1:0] RST_MAX_WINDOW     = 32'd1024;

   typedef struct packed {
      logic                 valid;
      logic [MODE_BITS-1:0] mode;
      logic                 loss;
   } event_type;

endpackage

// File: hdl/cwc_in_stage.sv
module cwc_in_stage (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [cwc_pkg::MODE_BITS-1:0] req_mode,
   input  logic                         req_loss_flag,
   input  logic                         take,
   output cwc_pkg::event_type           evt
);
   import cwc_pkg::*;

   logic                 valid_ff, valid_in;
   logic [MODE_BITS-1:0] mode_ff;
   logic                 loss_ff;
   logic                 load;

   assign req_stall = valid_ff && !take;
   assign load      = req_valid && !req_stall;
   assign valid_in  = load || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mode_ff <= req_mode;
         loss_ff <= req_loss_flag;
      end
   end

   assign evt = '{valid: valid_ff, mode: mode_ff, loss: loss_ff};

endmodule

// File: hdl/cwc_next.sv
module cwc_next #(
   parameter int WINDOW_BITS = 32
) (
   input  logic [cwc_pkg::MODE_BITS-1:0] mode,
   input  logic                         loss,
   input  logic [WINDOW_BITS-1:0]       window,
   input  logic [WINDOW_BITS-1:0]       threshold,
   input  logic [WINDOW_BITS-1:0]       inflight,
   input  logic [WINDOW_BITS-1:0]       min_window,
   input  logic [WINDOW_BITS-1:0]       max_window,
   output logic [WINDOW_BITS-1:0]       window_nx,
   output logic [WINDOW_BITS-1:0]       threshold_nx,
   output logic [WINDOW_BITS-1:0]       inflight_nx,
   output logic                         may_send_nx
);
   import cwc_pkg::*;

   localparam logic [WINDOW_BITS-1:0] ONES = '1;
   localparam logic [WINDOW_BITS-1:0] ONE  = WINDOW_BITS'(1);

   logic [WINDOW_BITS-1:0] grow_raw, grown, half, halved;

   always_comb begin
      if (window < threshold) begin
         grow_raw = window[WINDOW_BITS-1] ? ONES : {window[WINDOW_BITS-2:0], 1'b0};
      end else begin
         grow_raw = (&window) ? ONES : window + ONE;
      end
      grown  = (grow_raw < max_window) ? grow_raw : max_window;
      half   = window >> 1;
      halved = (half > min_window) ? half : min_window;
   end

   always_comb begin
      window_nx    = window;
      threshold_nx = threshold;
      inflight_nx  = inflight;
      unique case (mode)
         MODE_SENT: begin
            inflight_nx = (&inflight) ? inflight : inflight + ONE;
         end
         MODE_ACKED, MODE_LOST: begin
            inflight_nx = (inflight == '0) ? inflight : inflight - ONE;
         end
         MODE_ACK_RX: begin
            if (loss) begin
               window_nx    = halved;
               threshold_nx = halved;
            end else begin
               window_nx = grown;
            end
         end
         MODE_TIMEOUT: begin
            window_nx    = min_window;
            threshold_nx = halved;
         end
         MODE_DUP_ACK: begin
            window_nx    = halved;
            threshold_nx = halved;
         end
         MODE_AVOID: begin
            threshold_nx = window;
         end
         MODE_CLR_INFL: begin
            inflight_nx = '0;
         end
         default: begin
            inflight_nx = inflight;
         end
      endcase
      may_send_nx = inflight_nx < window_nx;
   end

endmodule

// File: hdl/congestion_window_controller_core.sv
// Channel  Handshake          Payload
// req      req_valid/stall    req_mode[2:0], req_loss_flag
// rsp      rsp_valid/stall    rsp_may_send, rsp_window_now, rsp_threshold_now,
//                             rsp_inflight_now
// csr      csr_valid/ready    csr_index, csr_wdata (ready always high)
//
// One word per cycle sustained while rsp_stall is low; an accepted word passes
// through the input register, then the state update into the result register.
// The state update is a single compare/shift/increment/min-max stage.
// Reset loads window 10, threshold 64, in-flight 0, min 1, max 1024.
// rsp_stall holds the result register; the input register then fills and
// req_stall rises.
module congestion_window_controller_core #(
   parameter int WINDOW_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [cwc_pkg::MODE_BITS-1:0]    req_mode,
   input  logic                            req_loss_flag,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_may_send,
   output logic [cwc_pkg::FIELD_BITS-1:0]   rsp_window_now,
   output logic [cwc_pkg::FIELD_BITS-1:0]   rsp_threshold_now,
   output logic [cwc_pkg::FIELD_BITS-1:0]   rsp_inflight_now,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cwc_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [cwc_pkg::FIELD_BITS-1:0]   csr_wdata
);
   import cwc_pkg::*;

   event_type evt;
   logic      take, csr_wr;

   logic [WINDOW_BITS-1:0] window_ff, threshold_ff, inflight_ff;
   logic [WINDOW_BITS-1:0] min_ff, max_ff;
   logic [WINDOW_BITS-1:0] window_in, threshold_in, inflight_in;
   logic [WINDOW_BITS-1:0] csr_val;
   logic                   may_send_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  may_send_ff;
   logic [FIELD_BITS-1:0] win_out_ff, thr_out_ff, infl_out_ff;

   cwc_in_stage u_in (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_loss_flag (req_loss_flag),
      .take          (take),
      .evt           (evt)
   );

   cwc_next #(.WINDOW_BITS(WINDOW_BITS)) u_next (
      .mode         (evt.mode),
      .loss         (evt.loss),
      .window       (window_ff),
      .threshold    (threshold_ff),
      .inflight     (inflight_ff),
      .min_window   (min_ff),
      .max_window   (max_ff),
      .window_nx    (window_in),
      .threshold_nx (threshold_in),
      .inflight_nx  (inflight_in),
      .may_send_nx  (may_send_in)
   );

   assign csr_ready    = 1'b1;
   assign csr_wr       = csr_valid && csr_ready;
   assign csr_val      = WINDOW_BITS'(csr_wdata);
   assign take         = evt.valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = take || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WINDOW_BITS'(RST_INIT_WINDOW);
         threshold_ff <= WINDOW_BITS'(RST_INIT_THRESHOLD);
         inflight_ff  <= '0;
         min_ff       <= WINDOW_BITS'(RST_MIN_WINDOW);
         max_ff       <= WINDOW_BITS'(RST_MAX_WINDOW);
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            window_ff    <= window_in;
            threshold_ff <= threshold_in;
            inflight_ff  <= inflight_in;
         end
         if (csr_wr) begin
            unique case (csr_index)
               CSR_INIT_WINDOW:    window_ff    <= csr_val;
               CSR_INIT_THRESHOLD: threshold_ff <= csr_val;
               CSR_MIN_WINDOW:     min_ff       <= csr_val;
               CSR_MAX_WINDOW:     max_ff       <= csr_val;
               default: begin
                  min_ff <= min_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         may_send_ff <= may_send_in;
         win_out_ff  <= FIELD_BITS'(window_in);
         thr_out_ff  <= FIELD_BITS'(threshold_in);
         infl_out_ff <= FIELD_BITS'(inflight_in);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_may_send      = may_send_ff;
   assign rsp_window_now    = win_out_ff;
   assign rsp_threshold_now = thr_out_ff;
   assign rsp_inflight_now  = infl_out_ff;

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      evt.valid && !take |=> evt.valid)
      else $error("input word dropped while result stalled");

   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      take && !csr_wr |=> rsp_valid && rsp_window_now == FIELD_BITS'(window_ff)
         && rsp_inflight_now == FIELD_BITS'(inflight_ff))
      else $error("result register out of step with state");

   a_sent_nonzero: assert property (@(posedge clock) disable iff (reset)
      take && evt.mode == MODE_SENT |=> inflight_ff != '0)
      else $error("in-flight count zero after sent");

endmodule

// File: tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cwc_pkg::*;

   localparam logic [CSR_IDX_BITS-1:0] CSR_UNMAPPED_LO = 8'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNMAPPED_HI = 8'hFF;
   localparam logic [FIELD_BITS-1:0]   ALL_ONES        = '1;

   typedef struct packed {
      logic                  may_send;
      logic [FIELD_BITS-1:0] window;
      logic [FIELD_BITS-1:0] threshold;
      logic [FIELD_BITS-1:0] inflight;
   } cwnd_status_type;

   logic                    clock;
   logic                    reset         = 1'b1;
   logic                    req_valid     = 1'b0;
   logic                    req_stall;
   logic [MODE_BITS-1:0]    req_mode      = MODE_SENT;
   logic                    req_loss_flag = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall     = 1'b0;
   logic                    rsp_may_send;
   logic [FIELD_BITS-1:0]   rsp_window_now;
   logic [FIELD_BITS-1:0]   rsp_threshold_now;
   logic [FIELD_BITS-1:0]   rsp_inflight_now;
   logic                    csr_valid     = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index     = CSR_INIT_WINDOW;
   logic [FIELD_BITS-1:0]   csr_wdata     = '0;

   // predicted controller state and registers
   logic [FIELD_BITS-1:0] cw_window;
   logic [FIELD_BITS-1:0] cw_threshold;
   logic [FIELD_BITS-1:0] cw_inflight;
   logic [FIELD_BITS-1:0] reg_init_window;
   logic [FIELD_BITS-1:0] reg_init_threshold;
   logic [FIELD_BITS-1:0] reg_min_window;
   logic [FIELD_BITS-1:0] reg_max_window;

   cwnd_status_type expected_status[$];
   int              mismatch_count = 0;
   int              snd_idle_pct   = 24;
   int              rcv_idle_pct   = 71;
   int              hold_len       = 0;

   congestion_window_controller_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_loss_flag     (req_loss_flag),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_may_send      (rsp_may_send),
      .rsp_window_now    (rsp_window_now),
      .rsp_threshold_now (rsp_threshold_now),
      .rsp_inflight_now  (rsp_inflight_now),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("congestion_window_controller_core verification failed");
      $finish;
   end

   function automatic void halve_window();
      logic [FIELD_BITS-1:0] half;
      half = cw_window >> 1;
      if (half < reg_min_window) half = reg_min_window;
      cw_window    = half;
      cw_threshold = half;
   endfunction

   function automatic void advance_cwnd(logic [MODE_BITS-1:0] mode, logic loss);
      logic [FIELD_BITS-1:0] grown;
      cwnd_status_type       status;
      case (mode)
         MODE_SENT: begin
            if (cw_inflight != ALL_ONES) cw_inflight = cw_inflight + 1;
         end
         MODE_ACKED, MODE_LOST: begin
            if (cw_inflight != 0) cw_inflight = cw_inflight - 1;
         end
         MODE_ACK_RX: begin
            if (loss) begin
               halve_window();
            end else begin
               if (cw_window < cw_threshold)
                  grown = cw_window[FIELD_BITS-1] ? ALL_ONES : cw_window << 1;
               else
                  grown = (cw_window == ALL_ONES) ? ALL_ONES : cw_window + 1;
               cw_window = (grown < reg_max_window) ? grown : reg_max_window;
            end
         end
         MODE_TIMEOUT: begin
            halve_window();
            cw_window = reg_min_window;
         end
         MODE_DUP_ACK: halve_window();
         MODE_AVOID:   cw_threshold = cw_window;
         default:      cw_inflight = '0;
      endcase
      status.may_send  = cw_inflight < cw_window;
      status.window    = cw_window;
      status.threshold = cw_threshold;
      status.inflight  = cw_inflight;
      expected_status.push_back(status);
   endfunction

   // receiver: random stalls, plus long hold-offs on request
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_len > 0) begin
            hold_left = hold_len;
            hold_len  = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
         end
      end
   end

   task automatic check_field(string name, logic [FIELD_BITS-1:0] exp_val,
                              logic [FIELD_BITS-1:0] act_val);
      if (exp_val !== act_val) begin
         mismatch_count++;
         $display("%0t %s mismatch: expected %h actual %h", $time, name, exp_val, act_val);
      end
   endtask

   always @(posedge clock) begin
      cwnd_status_type exp_word;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_status.size() == 0) begin
            mismatch_count++;
            $display("%0t unexpected word: expected none actual %h %h %h %h", $time,
                     rsp_may_send, rsp_window_now, rsp_threshold_now, rsp_inflight_now);
         end else begin
            exp_word = expected_status.pop_front();
            check_field("may_send", exp_word.may_send, rsp_may_send);
            check_field("window", exp_word.window, rsp_window_now);
            check_field("threshold", exp_word.threshold, rsp_threshold_now);
            check_field("inflight", exp_word.inflight, rsp_inflight_now);
         end
      end
   end

   task automatic send_event(logic [MODE_BITS-1:0] mode, logic loss);
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_loss_flag <= loss;
      do @(posedge clock); while (req_stall);
      advance_cwnd(mode, loss);
      if ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < snd_idle_pct);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_BITS-1:0] idx, logic [FIELD_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_INIT_WINDOW: begin
            reg_init_window = data;
            cw_window       = data;
         end
         CSR_INIT_THRESHOLD: begin
            reg_init_threshold = data;
            cw_threshold       = data;
         end
         CSR_MIN_WINDOW: reg_min_window = data;
         CSR_MAX_WINDOW: reg_max_window = data;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random_event();
      int                   pick;
      logic [MODE_BITS-1:0] mode;
      logic                 loss;
      pick = $urandom_range(99);
      if (pick < 28)      mode = MODE_SENT;
      else if (pick < 38) mode = MODE_ACKED;
      else if (pick < 46) mode = MODE_LOST;
      else if (pick < 78) mode = MODE_ACK_RX;
      else if (pick < 83) mode = MODE_TIMEOUT;
      else if (pick < 89) mode = MODE_DUP_ACK;
      else if (pick < 95) mode = MODE_AVOID;
      else                mode = MODE_CLR_INFL;
      if (mode == MODE_ACK_RX) loss = ($urandom_range(99) < 20);
      else                     loss = $urandom_range(1);
      send_event(mode, loss);
   endtask

   task automatic test_reset_defaults();
      send_event(MODE_ACKED, 1'b1);
      send_event(MODE_LOST, 1'b0);
      send_event(MODE_SENT, 1'b0);
      send_event(MODE_SENT, 1'b1);
      send_event(MODE_SENT, 1'b0);
      send_event(MODE_ACK_RX, 1'b0);
      send_event(MODE_ACK_RX, 1'b0);
      send_event(MODE_ACK_RX, 1'b1);
      send_event(MODE_DUP_ACK, 1'b1);
      send_event(MODE_AVOID, 1'b0);
      send_event(MODE_TIMEOUT, 1'b0);
      send_event(MODE_ACKED, 1'b0);
      send_event(MODE_LOST, 1'b1);
      send_event(MODE_CLR_INFL, 1'b0);
   endtask

   task automatic test_window_corners();
      drain_results();
      write_register(CSR_MIN_WINDOW, '0);
      write_register(CSR_INIT_WINDOW, '0);
      send_event(MODE_SENT, 1'b0);
      send_event(MODE_ACK_RX, 1'b0);
      send_event(MODE_ACKED, 1'b1);
      drain_results();
      // doubling past the top, then saturating increment
      write_register(CSR_MAX_WINDOW, ALL_ONES);
      write_register(CSR_INIT_THRESHOLD, ALL_ONES);
      write_register(CSR_INIT_WINDOW, 32'h8000_0001);
      send_event(MODE_ACK_RX, 1'b0);
      send_event(MODE_ACK_RX, 1'b0);
      send_event(MODE_AVOID, 1'b1);
      drain_results();
      // window above the ceiling gets clamped
      write_register(CSR_INIT_THRESHOLD, '0);
      write_register(CSR_MAX_WINDOW, 32'd16);
      write_register(CSR_INIT_WINDOW, 32'd1000);
      send_event(MODE_ACK_RX, 1'b0);
      drain_results();
      write_register(CSR_MAX_WINDOW, '0);
      send_event(MODE_ACK_RX, 1'b0);
      drain_results();
      write_register(CSR_MIN_WINDOW, ALL_ONES);
      send_event(MODE_DUP_ACK, 1'b0);
      send_event(MODE_TIMEOUT, 1'b1);
      send_event(MODE_ACK_RX, 1'b1);
      drain_results();
      write_register(CSR_UNMAPPED_LO, 32'h5A5A_A5A5);
      write_register(CSR_UNMAPPED_HI, ALL_ONES);
      send_event(MODE_CLR_INFL, 1'b1);
      send_event(MODE_SENT, 1'b1);
   endtask

   task automatic test_backpressure();
      drain_results();
      write_register(CSR_MIN_WINDOW, RST_MIN_WINDOW);
      write_register(CSR_MAX_WINDOW, RST_MAX_WINDOW);
      write_register(CSR_INIT_THRESHOLD, RST_INIT_THRESHOLD);
      write_register(CSR_INIT_WINDOW, RST_INIT_WINDOW);
      snd_idle_pct = 0;
      hold_len     = 48;
      repeat (20) send_random_event();
      drain_results();
      repeat (10) send_random_event();
      drain_results();
   endtask

   task automatic test_random_traffic(int setting, int snd_pct, int rcv_pct, int count);
      drain_results();
      snd_idle_pct = snd_pct;
      rcv_idle_pct = rcv_pct;
      case (setting)
         0: begin
            write_register(CSR_MIN_WINDOW, RST_MIN_WINDOW);
            write_register(CSR_MAX_WINDOW, RST_MAX_WINDOW);
            write_register(CSR_INIT_THRESHOLD, RST_INIT_THRESHOLD);
            write_register(CSR_INIT_WINDOW, RST_INIT_WINDOW);
         end
         1: begin
            write_register(CSR_MIN_WINDOW, $urandom_range(0, 5));
            write_register(CSR_MAX_WINDOW, $urandom_range(1, 300));
            write_register(CSR_INIT_THRESHOLD, $urandom_range(0, 200));
            write_register(CSR_INIT_WINDOW, $urandom_range(0, 40));
         end
         default: begin
            write_register(CSR_MIN_WINDOW, $urandom);
            write_register(CSR_MAX_WINDOW, ALL_ONES);
            write_register(CSR_INIT_THRESHOLD, $urandom);
            write_register(CSR_INIT_WINDOW, ALL_ONES - $urandom_range(0, 2));
         end
      endcase
      for (int i = 0; i < count; i++) begin
         send_random_event();
         if (i % 50 == 49) drain_results();
      end
   endtask

   initial begin
      reg_init_window    = RST_INIT_WINDOW;
      reg_init_threshold = RST_INIT_THRESHOLD;
      reg_min_window     = RST_MIN_WINDOW;
      reg_max_window     = RST_MAX_WINDOW;
      cw_window          = RST_INIT_WINDOW;
      cw_threshold       = RST_INIT_THRESHOLD;
      cw_inflight        = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_window_corners();
      test_backpressure();
      test_random_traffic(0, 24, 71, 170);
      test_random_traffic(1, 71, 24, 170);
      test_random_traffic(2, 0, 0, 170);
      drain_results();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && expected_status.size() == 0) begin
         $display("congestion_window_controller_core verification clean");
      end else begin
         $display("congestion_window_controller_core verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/cwc_pkg.sv
hdl/cwc_in_stage.sv
hdl/cwc_next.sv
hdl/congestion_window_controller_core.sv
tb/tb.sv
